/* hdl/bsdo_pkg.sv */
// Shared types and default sizes for the bounded stack with oldest-entry drop.
`default_nettype none
package bsdo_pkg;

  localparam int unsigned DepthDef     = 16;
  localparam int unsigned DataWidthDef = 32;
  localparam int unsigned KindWidth    = 2;

  typedef enum logic [KindWidth-1:0] {
    KIND_PUSH = 2'd0,
    KIND_POP  = 2'd1,
    KIND_PEEK = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    SHIFT_HOLD = 2'd0,
    SHIFT_PUSH = 2'd1,
    SHIFT_POP  = 2'd2
  } shift_e;

endpackage
`default_nettype wire

/* hdl/bsdo_cell.sv */
// One storage cell of the stack chain, loading from its upper or lower neighbor.
`default_nettype none
module bsdo_cell
  import bsdo_pkg::*;
#(
  parameter int unsigned DataWidth = DataWidthDef
) (
  input  wire logic                 clk_i,
  input  wire shift_e               shift_i,
  input  wire logic [DataWidth-1:0] push_data_i,
  input  wire logic [DataWidth-1:0] pop_data_i,
  output logic      [DataWidth-1:0] data_o
);

  logic [DataWidth-1:0] data_q;

  always_ff @(posedge clk_i) begin
    case (shift_i)
      SHIFT_PUSH: data_q <= push_data_i;
      SHIFT_POP:  data_q <= pop_data_i;
      default:    data_q <= data_q;
    endcase
  end

  assign data_o = data_q;

endmodule
`default_nettype wire

/* hdl/bounded_stack_drop_oldest.sv */
// Top level: bounded LIFO stack built as a chain of cells, dropping the oldest when full.
// A result is registered and appears on the master side in the cycle after its input is accepted.
// Throughput: one operation per cycle unless the output stalls; all cells shift on push or pop.
// The top of stack always sits in cell 0, so a push onto a full stack pushes the
// bottom entry off the end of the chain.
// Reset clears the fill count and the output valid; cell contents are not reset.
`default_nettype none
module bounded_stack_drop_oldest
  import bsdo_pkg::*;
#(
  parameter int unsigned Depth     = DepthDef,
  parameter int unsigned DataWidth = DataWidthDef,
  localparam int unsigned CntWidth = $clog2(Depth + 1),
  localparam int unsigned InWidth  = ((DataWidth + 7) / 8) * 8,
  localparam int unsigned ResWidth = DataWidth + 2 + CntWidth,
  localparam int unsigned OutWidth = ((ResWidth + 7) / 8) * 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  input  wire logic [InWidth-1:0]  s_axis_tdata_i,   // value
  input  wire logic [KindWidth-1:0] s_axis_tuser_i,  // kind
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  output logic      [OutWidth-1:0] m_axis_tdata_o    // data, empty_flag, dropped_flag, fill_count
);

  logic [DataWidth-1:0] cell_data [Depth];
  shift_e               shift;
  logic                 accept;
  logic                 full;
  logic                 is_empty;
  kind_e                kind;
  logic [CntWidth-1:0]  count_q, count_d;
  logic                 out_valid_q;
  logic [ResWidth-1:0]  res_q, res_d;
  logic [DataWidth-1:0] res_data;
  logic                 res_empty;
  logic                 res_dropped;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign kind            = kind_e'(s_axis_tuser_i);
  assign full            = (count_q == CntWidth'(Depth));
  assign is_empty        = (count_q == '0);

  always_comb begin
    shift       = SHIFT_HOLD;
    count_d     = count_q;
    res_data    = '0;
    res_empty   = 1'b0;
    res_dropped = 1'b0;
    case (kind)
      KIND_PUSH: begin
        shift       = SHIFT_PUSH;
        res_dropped = full;
        if (!full) begin
          count_d = count_q + CntWidth'(1);
        end
      end
      KIND_POP: begin
        if (is_empty) begin
          res_empty = 1'b1;
        end else begin
          shift    = SHIFT_POP;
          count_d  = count_q - CntWidth'(1);
          res_data = cell_data[0];
        end
      end
      KIND_PEEK: begin
        if (is_empty) begin
          res_empty = 1'b1;
        end else begin
          res_data = cell_data[0];
        end
      end
      default: begin
        shift = SHIFT_HOLD;
      end
    endcase
    if (!accept) begin
      shift = SHIFT_HOLD;
    end
    res_d = {count_d, res_dropped, res_empty, res_data};
  end

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic [DataWidth-1:0] push_src;
    logic [DataWidth-1:0] pop_src;
    if (i == 0) begin : g_first
      assign push_src = s_axis_tdata_i[DataWidth-1:0];
    end else begin : g_mid_push
      assign push_src = cell_data[i-1];
    end
    if (i == Depth - 1) begin : g_last
      assign pop_src = cell_data[i];
    end else begin : g_mid_pop
      assign pop_src = cell_data[i+1];
    end
    bsdo_cell #(
      .DataWidth(DataWidth)
    ) u_cell (
      .clk_i      (clk_i),
      .shift_i    (shift),
      .push_data_i(push_src),
      .pop_data_i (pop_src),
      .data_o     (cell_data[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OutWidth'(res_q);

endmodule
`default_nettype wire
